@@ hdl/pal_pkg.sv @@
// Shared types and codes for the positional array list.
package pal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_MODIFY = 3'd1;
    localparam logic [2:0] FN_READ   = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_FIND   = 3'd4;
    localparam logic [2:0] FN_QUERY  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [6:0]  position;
        logic [31:0] key;
        logic [31:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic [31:0] out_payload;
        logic [6:0]  found_position;
        logic [6:0]  count;
        logic        is_empty;
    } t_out_item;

endpackage

@@ hdl/pal_mem.sv @@
// Entry store: one write port and one read port with registered read data.
module pal_mem #(
    parameter int DEPTH = pal_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/pal_ctrl.sv @@
// Request sequencer: decodes a request, walks the entry store and builds the result.
module pal_ctrl #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pal_pkg::t_in_item   i_item,
    output logic                o_res_valid,
    input  logic                i_res_take,
    output pal_pkg::t_out_item  o_res,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [63:0]         o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [63:0]         i_rd_data
);

    localparam int WW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHUP,
        S_SHDN,
        S_WRNEW,
        S_RDWAIT,
        S_FIND,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_tgt;
    logic [AW-1:0] r_wa;
    logic [AW-1:0] r_ca;
    logic          r_pend;
    logic          r_cv;
    logic [2:0]    r_func;
    logic [31:0]   r_key;
    logic [31:0]   r_pay;
    logic [1:0]    r_status;
    logic [31:0]   r_rk;
    logic [31:0]   r_rp;
    logic [6:0]    r_fpos;

    logic          accept;
    logic [WW-1:0] pw;
    logic [WW-1:0] nw;
    logic [WW-1:0] pm1;
    logic [WW-1:0] fpos_w;
    logic [WW-1:0] cnt_w;
    logic          pos_ok;
    logic          ins_ok;
    logic          full;
    logic          key_hit;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);
    assign pw      = WW'(i_item.position);
    assign nw      = WW'(r_cnt);
    assign pm1     = pw - WW'(1);
    assign pos_ok  = (pw != '0) && (pw <= nw);
    assign ins_ok  = (pw != '0) && (pw <= nw + WW'(1));
    assign full    = (nw >= WW'(CAPACITY));
    assign key_hit = r_cv && (i_rd_data[63:32] == r_key);
    assign fpos_w  = WW'(r_ca) + WW'(1);
    assign cnt_w   = WW'(r_cnt);

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_rd_en   = accept && (i_item.func == pal_pkg::FN_READ);
                o_rd_addr = pm1[AW-1:0];
            end
            S_SHUP, S_SHDN: o_rd_en = 1'b1;
            S_FIND:         o_rd_en = (r_idx != r_cnt);
            default:        o_rd_en = 1'b0;
        endcase
    end

    always_comb begin
        if (r_pend) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_wa;
            o_wr_data = i_rd_data;
        end else begin
            o_wr_en   = (r_state == S_WRNEW);
            o_wr_addr = r_tgt;
            o_wr_data = {r_key, r_pay};
        end
    end

    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.out_key        = r_rk;
    assign o_res.out_payload    = r_rp;
    assign o_res.found_position = r_fpos;
    assign o_res.count          = cnt_w[6:0];
    assign o_res.is_empty       = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_cv    <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func   <= i_item.func;
                        r_key    <= i_item.key;
                        r_pay    <= i_item.payload;
                        r_tgt    <= pm1[AW-1:0];
                        r_status <= pal_pkg::ST_OK;
                        r_rk     <= '0;
                        r_rp     <= '0;
                        r_fpos   <= '0;
                        r_cv     <= 1'b0;
                        r_state  <= S_DONE;
                        case (i_item.func)
                            pal_pkg::FN_INSERT: begin
                                if (full) begin
                                    r_status <= pal_pkg::ST_FULL;
                                end else if (!ins_ok) begin
                                    r_status <= pal_pkg::ST_RANGE;
                                end else if (nw == pm1) begin
                                    r_state <= S_WRNEW;
                                end else begin
                                    r_idx   <= r_cnt - CW'(1);
                                    r_state <= S_SHUP;
                                end
                            end
                            pal_pkg::FN_MODIFY: begin
                                if (!pos_ok) begin
                                    r_status <= pal_pkg::ST_RANGE;
                                end else begin
                                    r_state <= S_WRNEW;
                                end
                            end
                            pal_pkg::FN_READ: begin
                                if (!pos_ok) begin
                                    r_status <= pal_pkg::ST_RANGE;
                                end else begin
                                    r_state <= S_RDWAIT;
                                end
                            end
                            pal_pkg::FN_DELETE: begin
                                if (!pos_ok) begin
                                    r_status <= pal_pkg::ST_RANGE;
                                end else if (pw == nw) begin
                                    r_cnt <= r_cnt - CW'(1);
                                end else begin
                                    r_idx   <= pw[CW-1:0];
                                    r_state <= S_SHDN;
                                end
                            end
                            pal_pkg::FN_FIND: begin
                                r_idx    <= '0;
                                r_status <= pal_pkg::ST_NOTFOUND;
                                r_state  <= S_FIND;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SHUP: begin
                    r_pend <= 1'b1;
                    r_wa   <= r_idx[AW-1:0] + AW'(1);
                    if (r_idx[AW-1:0] == r_tgt) begin
                        r_state <= S_WRNEW;
                    end else begin
                        r_idx <= r_idx - CW'(1);
                    end
                end
                S_SHDN: begin
                    r_pend <= 1'b1;
                    r_wa   <= r_idx[AW-1:0] - AW'(1);
                    if ((r_idx + CW'(1)) == r_cnt) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_WRNEW: begin
                    if (!r_pend) begin
                        if (r_func == pal_pkg::FN_INSERT) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_FLUSH: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_DONE;
                end
                S_RDWAIT: begin
                    r_rk    <= i_rd_data[63:32];
                    r_rp    <= i_rd_data[31:0];
                    r_state <= S_DONE;
                end
                S_FIND: begin
                    if (key_hit) begin
                        r_status <= pal_pkg::ST_OK;
                        r_fpos   <= fpos_w[6:0];
                        r_cv     <= 1'b0;
                        r_state  <= S_DONE;
                    end else if (r_idx != r_cnt) begin
                        r_cv  <= 1'b1;
                        r_ca  <= r_idx[AW-1:0];
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_cv    <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/positional_array_list_unit.sv @@
// Top level of the positional array list: sequencer, entry store and result register.
// Modify, read, query and rejected requests touch the entry store at most once.
// Insert at p shifts the entries from p on up in turn, delete shifts those behind p down,
// and find reads from the first entry on, as the store has one read and one write port.
// One request is worked at a time; the next is taken while a result waits in the output.
// Synchronous reset empties the list; the entry store itself is not cleared.
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pal_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output pal_pkg::t_out_item o_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               res_valid;
    logic               res_take;
    pal_pkg::t_out_item res;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [63:0]        wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [63:0]        rd_data;
    logic               r_out_valid;
    pal_pkg::t_out_item r_out;

    pal_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    pal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_take = res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

@@ hdl/pal_checker.sv @@
// Port-level checks for the positional array list, bound to the top level.
module pal_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input pal_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_ready,
    input pal_pkg::t_out_item o_item
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.is_empty == (o_item.count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_not_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status == pal_pkg::ST_NOTFOUND) |->
            (o_item.found_position == 7'd0) && (o_item.out_key == 32'd0))
        else $error("failed find carries data");

    a_found_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.found_position != 7'd0) |-> (o_item.status == pal_pkg::ST_OK))
        else $error("match reported with error status");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (.*);

@@ sim/positional_array_list_unit_tb.sv @@
// Self-checking testbench for the positional array list unit with a scoreboard predictor.
`timescale 1ns / 1ps

module positional_array_list_unit_tb;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 850;
    localparam int SETTLE_CYCLES = 80;

    class list_scoreboard;
        logic [63:0]        entries [pal_pkg::CAPACITY_DEF];
        int                 n_entries;
        int                 errors;
        pal_pkg::t_out_item expected_q [$];

        function new();
            n_entries = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] key_at(int p);
            return entries[p - 1][63:32];
        endfunction

        function void note_request(pal_pkg::t_in_item req);
            pal_pkg::t_out_item r;
            int                 p;
            r = '0;
            p = int'(req.position);
            case (req.func)
                pal_pkg::FN_INSERT: begin
                    if (n_entries >= pal_pkg::CAPACITY_DEF) begin
                        r.status = pal_pkg::ST_FULL;
                    end else if (p < 1 || p > n_entries + 1) begin
                        r.status = pal_pkg::ST_RANGE;
                    end else begin
                        for (int j = n_entries; j > p - 1; j--) begin
                            entries[j] = entries[j - 1];
                        end
                        entries[p - 1] = {req.key, req.payload};
                        n_entries++;
                    end
                end
                pal_pkg::FN_MODIFY: begin
                    if (p < 1 || p > n_entries) begin
                        r.status = pal_pkg::ST_RANGE;
                    end else begin
                        entries[p - 1] = {req.key, req.payload};
                    end
                end
                pal_pkg::FN_READ: begin
                    if (p < 1 || p > n_entries) begin
                        r.status = pal_pkg::ST_RANGE;
                    end else begin
                        r.out_key     = entries[p - 1][63:32];
                        r.out_payload = entries[p - 1][31:0];
                    end
                end
                pal_pkg::FN_DELETE: begin
                    if (p < 1 || p > n_entries) begin
                        r.status = pal_pkg::ST_RANGE;
                    end else begin
                        for (int j = p - 1; j + 1 < n_entries; j++) begin
                            entries[j] = entries[j + 1];
                        end
                        n_entries--;
                    end
                end
                pal_pkg::FN_FIND: begin
                    r.status = pal_pkg::ST_NOTFOUND;
                    for (int j = 0; j < n_entries; j++) begin
                        if (r.status == pal_pkg::ST_NOTFOUND &&
                            entries[j][63:32] == req.key) begin
                            r.status         = pal_pkg::ST_OK;
                            r.found_position = 7'(j + 1);
                        end
                    end
                end
                default: begin
                end
            endcase
            r.count    = 7'(n_entries);
            r.is_empty = (n_entries == 0);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(pal_pkg::t_out_item got);
            pal_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_key", want.out_key, got.out_key);
            compare_field("out_payload", want.out_payload, got.out_payload);
            compare_field("found_position", 32'(want.found_position), 32'(got.found_position));
            compare_field("count", 32'(want.count), 32'(got.count));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_ready = 1'b0;
    pal_pkg::t_in_item  in_item = '0;
    logic               o_ready;
    logic               o_valid;
    pal_pkg::t_out_item o_item;

    list_scoreboard sb = new();
    bit             send_steady = 1'b0;
    bit             recv_steady = 1'b0;
    int             n_sent = 0;
    int             stall_cycles = 0;

    positional_array_list_unit #(
        .CAPACITY(pal_pkg::CAPACITY_DEF)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(o_ready),
        .i_item(in_item),
        .o_valid(o_valid),
        .i_ready(out_ready),
        .o_item(o_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input pal_pkg::t_in_item req);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!o_ready);
        sb.note_request(req);
        n_sent++;
    endtask

    task automatic send_fields(input logic [2:0] func, input logic [6:0] position,
                               input logic [31:0] key, input logic [31:0] payload);
        pal_pkg::t_in_item req;
        req.func     = func;
        req.position = position;
        req.key      = key;
        req.payload  = payload;
        send_request(req);
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    function automatic pal_pkg::t_in_item make_request(t_phase ph);
        pal_pkg::t_in_item req;
        int                n;
        int                roll;
        n    = sb.n_entries;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                req.func = (roll < 80) ? pal_pkg::FN_INSERT : 3'($urandom_range(1, 7));
            end
            PH_DRAIN: begin
                req.func = (roll < 75) ? pal_pkg::FN_DELETE : 3'($urandom_range(0, 7));
            end
            default: begin
                if (roll < 25) begin
                    req.func = pal_pkg::FN_INSERT;
                end else if (roll < 45) begin
                    req.func = pal_pkg::FN_DELETE;
                end else begin
                    req.func = 3'($urandom_range(1, 7));
                end
            end
        endcase
        if ($urandom_range(0, 99) < 85 && (n > 0 || req.func == pal_pkg::FN_INSERT)) begin
            req.position = 7'($urandom_range(1, (req.func == pal_pkg::FN_INSERT) ? n + 1 : n));
        end else begin
            req.position = 7'($urandom_range(0, 127));
        end
        req.key = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 15)) : $urandom;
        if (req.func == pal_pkg::FN_FIND && n > 0 && $urandom_range(0, 99) < 60) begin
            req.key = sb.key_at($urandom_range(1, n));
        end
        req.payload = $urandom;
        return req;
    endfunction

    task automatic run_phase(t_phase ph);
        int  n;
        int  tail;
        bit  done;
        n    = 0;
        tail = 0;
        done = 1'b0;
        while (!done) begin
            send_request(make_request(ph));
            n++;
            case (ph)
                PH_FILL: begin
                    if (sb.n_entries == pal_pkg::CAPACITY_DEF) tail++;
                end
                PH_DRAIN: begin
                    if (sb.n_entries == 0) tail++;
                end
                default: begin
                    tail++;
                end
            endcase
            done = (ph == PH_MIXED) ? (tail >= 100) : (tail >= 10 || n >= 300);
        end
    endtask

    initial begin
        int     round;
        t_phase ph;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_fields(pal_pkg::FN_QUERY, 7'd0, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_FIND, 7'd0, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_READ, 7'd1, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_DELETE, 7'd1, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_MODIFY, 7'd1, 32'h1, 32'h1);
        send_fields(pal_pkg::FN_INSERT, 7'd0, 32'h1, 32'h1);
        send_fields(pal_pkg::FN_INSERT, 7'd2, 32'h1, 32'h1);
        send_fields(pal_pkg::FN_INSERT, 7'd1, 32'hFFFF_FFFF, 32'h0);
        send_fields(pal_pkg::FN_INSERT, 7'd2, 32'h0, 32'hFFFF_FFFF);
        send_fields(pal_pkg::FN_INSERT, 7'd1, 32'h5, 32'hA5A5_A5A5);
        send_fields(pal_pkg::FN_INSERT, 7'd2, 32'h0, 32'h1);
        send_fields(pal_pkg::FN_FIND, 7'd0, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_FIND, 7'd0, 32'h1234_5678, 32'h0);
        send_fields(pal_pkg::FN_READ, 7'd4, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_READ, 7'd5, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_READ, 7'd127, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_MODIFY, 7'd3, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_fields(pal_pkg::FN_MODIFY, 7'd5, 32'h7, 32'h7);
        send_fields(3'($urandom_range(6, 6)), 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(3'($urandom_range(7, 7)), 7'd1, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_DELETE, 7'd1, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_DELETE, 7'd3, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_DELETE, 7'd0, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_QUERY, 7'd127, 32'h0, 32'h0);
        send_fields(pal_pkg::FN_READ, 7'd2, 32'h0, 32'h0);
        drain_wait();

        round = 0;
        while (n_sent < ITEM_TARGET - 25) begin
            case (round % 3)
                0:       ph = PH_FILL;
                1:       ph = PH_DRAIN;
                default: ph = PH_MIXED;
            endcase
            send_steady = ($urandom_range(0, 3) == 0);
            run_phase(ph);
            drain_wait();
            round++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = recv_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_valid);
            sb.check_result(o_item);
            if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_ready) || (o_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, sb.pending());
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
